// ----- design/lbaf_pkg.sv -----
// Package for the LBA interval rule flattener.
// Holds command codes, register indexes and reset constants; no dependencies.
package lbaf_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int LBA_BITS_DEF    = 48;
    localparam int TARGET_BITS     = 8;
    localparam int CFG_IDX_BITS    = 1;

    // Input command codes
    localparam logic CMD_HINT = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEVICE_BLOCKS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DFLT_DEST     = 1'b1;

    localparam logic [63:0]            DEVICE_BLOCKS_RST = 64'd1048576;
    localparam logic [TARGET_BITS-1:0] DFLT_DEST_RST     = '0;

endpackage

// ----- design/lba_interval_rule_flattener.sv -----
// LBA interval rule flattener: turns sorted LBA hints into a gapless rule table.
// Depends on lbaf_pkg. The hint stack lives in one synchronous memory.
//
// Usage:
//   Input channel (in_valid/in_stall) carries a hint (cmd = 0) or an end-of-list
//   command (cmd = 1). Output channel (out_valid/out_stall) carries rule items;
//   last_of_run flags the final rule caused by one input, table_done the final
//   rule of a table. Configuration (cfg_we/cfg_index/cfg_data) writes the
//   device size or the default rule's target; write only while the block is idle.
//   Items are taken one at a time: in_stall stays high from acceptance until
//   the last rule of that item has been handed to the output register.
//   A skipped hint is dropped at acceptance. A hint that emits one rule and is
//   pushed passes through accept, stack memory read, evaluate and push, flush.
//   Each pop reads the new top from stack memory, then compares it; a rule
//   from the new top is emitted in a further evaluate step. An end command
//   pops every stack entry, emitting a rule from each until the device end.
//   Rules are staged in a holding register until the next rule or the end of
//   the item shows whether they are last; a stalled output holds its payload
//   and blocks further rules once the holding register is full.
//   Reset clears the stack to the default entry, the sticky overflow flag
//   and the configuration registers to their reset values; no clearing pass.
module lba_interval_rule_flattener #(
    parameter int STACK_DEPTH = lbaf_pkg::STACK_DEPTH_DEF,
    parameter int LBA_BITS    = lbaf_pkg::LBA_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             cmd,
    input  logic [LBA_BITS-1:0]              hint_first_lba,
    input  logic [LBA_BITS-1:0]              hint_blocks,
    input  logic [lbaf_pkg::TARGET_BITS-1:0] hint_dest,
    input  logic [LBA_BITS-1:0]              hint_dest_lba,
    input  logic                             target_usable,
    input  logic                             target_available,
    input  logic                             authoritative,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [LBA_BITS-1:0]              rule_first_lba,
    output logic [lbaf_pkg::TARGET_BITS-1:0] rule_target,
    output logic [LBA_BITS-1:0]              rule_target_lba,
    output logic                             is_default,
    output logic                             overflowed,
    output logic                             last_of_run,
    output logic                             table_done,
    input  logic                             cfg_we,
    input  logic [lbaf_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [LBA_BITS-1:0]              cfg_data
);

    localparam int SLOTS = STACK_DEPTH + 1;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int TB    = lbaf_pkg::TARGET_BITS;

    typedef struct packed {
        logic [LBA_BITS-1:0] first;
        logic [LBA_BITS-1:0] last;
        logic [TB-1:0]       target;
        logic [LBA_BITS-1:0] target_lba;
    } entry_t;

    typedef struct packed {
        logic [LBA_BITS-1:0] first_lba;
        logic [TB-1:0]       target;
        logic [LBA_BITS-1:0] target_lba;
        logic                is_dflt;
        logic                ovf;
    } rule_t;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_EVAL, S_FIN} state_t;

    entry_t mem [STACK_DEPTH];
    entry_t mem_rd_reg;

    state_t               state_reg;
    logic [CW-1:0]        count_reg;
    logic [LBA_BITS-1:0]  nu_reg;
    logic                 end_reg;
    logic                 ovf_reg;
    logic                 drain_reg;
    logic                 popping_reg;
    entry_t               hint_reg;
    logic [LBA_BITS-1:0]  dev_blocks_reg;
    logic [TB-1:0]        dflt_target_reg;
    rule_t                pend_reg;
    logic                 pend_valid_reg;
    rule_t                out_reg;
    logic                 out_valid_reg;
    logic                 out_last_reg;
    logic                 out_done_reg;

    logic [LBA_BITS-1:0]  dev_end;
    entry_t               bottom;
    entry_t               top;
    logic                 out_free;
    logic                 can_emit;
    logic                 loop_cond;
    logic                 push_go;
    logic                 push_wr;
    logic                 emit_go;
    logic                 out_load;
    logic [LBA_BITS-1:0]  adv_nu1;
    logic [LBA_BITS-1:0]  adv_nu;
    logic                 adv_end;
    logic                 at_idle;
    rule_t                new_rule;
    logic [LBA_BITS-1:0]  blen;
    logic [LBA_BITS-1:0]  bm1;
    logic [LBA_BITS-1:0]  h_last;
    logic                 skip;

    always_comb
    begin
        dev_end = (dev_blocks_reg == '0) ? LBA_BITS'(1) : dev_blocks_reg;
        bottom.first      = '0;
        bottom.last       = dev_end - LBA_BITS'(1);
        bottom.target     = dflt_target_reg;
        bottom.target_lba = '0;
        top = (count_reg == CW'(1)) ? bottom : mem_rd_reg;
        out_free = !out_valid_reg || !out_stall;
        can_emit = !pend_valid_reg || out_free;
        at_idle  = (state_reg == S_IDLE);

        // Advance past the top extent
        adv_nu1 = (nu_reg < top.last) ? top.last : nu_reg;
        if (adv_nu1 >= dev_end)
        begin
            adv_nu  = adv_nu1;
            adv_end = 1'b1;
        end
        else
        begin
            adv_nu  = adv_nu1 + LBA_BITS'(1);
            adv_end = (adv_nu >= dev_end);
        end

        new_rule.first_lba  = nu_reg;
        new_rule.target     = top.target;
        new_rule.target_lba = nu_reg - top.first + top.target_lba;
        new_rule.is_dflt    = (count_reg == CW'(1));
        new_rule.ovf        = ovf_reg;

        loop_cond = (hint_reg.first > nu_reg) && (count_reg != '0) && !end_reg;
        push_go = (state_reg == S_EVAL) && !drain_reg && !popping_reg &&
                  (!loop_cond || (can_emit && top.last >= hint_reg.first));
        push_wr = push_go && (count_reg != '0) && !end_reg && (count_reg < CW'(SLOTS));

        // A new rule enters the holding register as the staged one moves out, or the flush moves it out
        emit_go  = (state_reg == S_EVAL) && !popping_reg && can_emit && !end_reg &&
                   (count_reg != '0) && (drain_reg || loop_cond);
        out_load = pend_valid_reg && (emit_go || ((state_reg == S_FIN) && out_free));

        // Hint extent end, saturated, and the skip test
        blen   = (hint_blocks == '0) ? LBA_BITS'(1) : hint_blocks;
        bm1    = blen - LBA_BITS'(1);
        h_last = (bm1 > ~hint_first_lba) ? '1 : hint_first_lba + bm1;
        skip   = !target_usable || (!authoritative && !target_available) ||
                 end_reg || (count_reg == '0) || (hint_first_lba >= dev_end);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            mem_rd_reg <= mem[AW'(count_reg - CW'(2))];
        end
        if (push_wr)
        begin
            mem[AW'(count_reg - CW'(1))] <= hint_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= CW'(1);
            nu_reg          <= '0;
            end_reg         <= 1'b0;
            ovf_reg         <= 1'b0;
            drain_reg       <= 1'b0;
            popping_reg     <= 1'b0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            dev_blocks_reg  <= LBA_BITS'(lbaf_pkg::DEVICE_BLOCKS_RST);
            dflt_target_reg <= lbaf_pkg::DFLT_DEST_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lbaf_pkg::CFG_DEVICE_BLOCKS: dev_blocks_reg  <= cfg_data;
                    lbaf_pkg::CFG_DFLT_DEST:     dflt_target_reg <= cfg_data[TB-1:0];
                    default: ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        hint_reg.first      <= hint_first_lba;
                        hint_reg.last       <= h_last;
                        hint_reg.target     <= hint_dest;
                        hint_reg.target_lba <= hint_dest_lba;
                        drain_reg   <= (cmd == lbaf_pkg::CMD_END);
                        popping_reg <= 1'b0;
                        if (cmd == lbaf_pkg::CMD_END || !skip)
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (popping_reg)
                    begin
                        if (count_reg != '0 && (end_reg || nu_reg > top.last))
                        begin
                            count_reg <= count_reg - CW'(1);
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            popping_reg <= 1'b0;
                        end
                    end
                    else if (drain_reg)
                    begin
                        if (count_reg == '0)
                        begin
                            state_reg <= S_FIN;
                        end
                        else if (end_reg || can_emit)
                        begin
                            if (!end_reg)
                            begin
                                pend_reg       <= new_rule;
                                pend_valid_reg <= 1'b1;
                                if (pend_valid_reg)
                                begin
                                    out_reg      <= pend_reg;
                                    out_last_reg <= 1'b0;
                                    out_done_reg <= 1'b0;
                                end
                                nu_reg  <= adv_nu;
                                end_reg <= adv_end;
                            end
                            count_reg   <= count_reg - CW'(1);
                            popping_reg <= 1'b1;
                            state_reg   <= S_READ;
                        end
                    end
                    else if (loop_cond)
                    begin
                        if (can_emit)
                        begin
                            pend_reg       <= new_rule;
                            pend_valid_reg <= 1'b1;
                            if (pend_valid_reg)
                            begin
                                out_reg      <= pend_reg;
                                out_last_reg <= 1'b0;
                                out_done_reg <= 1'b0;
                            end
                            if (top.last >= hint_reg.first)
                            begin
                                // hint lands inside the top extent: push now, or set overflow if the stack is full
                                nu_reg <= hint_reg.first;
                                if (push_wr)
                                begin
                                    count_reg <= count_reg + CW'(1);
                                end
                                else if (count_reg != '0 && !end_reg)
                                begin
                                    ovf_reg <= 1'b1;
                                end
                                state_reg <= S_FIN;
                            end
                            else
                            begin
                                nu_reg      <= adv_nu;
                                end_reg     <= adv_end;
                                count_reg   <= count_reg - CW'(1);
                                popping_reg <= 1'b1;
                                state_reg   <= S_READ;
                            end
                        end
                    end
                    else
                    begin
                        if (push_wr)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        else if (count_reg != '0 && !end_reg)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_reg        <= pend_reg;
                            out_last_reg   <= 1'b1;
                            out_done_reg   <= drain_reg;
                            pend_valid_reg <= 1'b0;
                        end
                        if (drain_reg)
                        begin
                            count_reg <= CW'(1);
                            nu_reg    <= '0;
                            end_reg   <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall        = !at_idle;
    assign out_valid       = out_valid_reg;
    assign rule_first_lba  = out_reg.first_lba;
    assign rule_target     = out_reg.target;
    assign rule_target_lba = out_reg.target_lba;
    assign is_default      = out_reg.is_dflt;
    assign overflowed      = out_reg.ovf;
    assign last_of_run     = out_last_reg;
    assign table_done      = out_done_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOTS))
        else $error("stack count beyond capacity");

    a_idle_has_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        at_idle |-> (count_reg != '0))
        else $error("idle with empty stack");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        at_idle |-> !pend_valid_reg)
        else $error("rule left pending at idle");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg) |-> out_last_reg)
        else $error("table end without run end");

endmodule

// ----- tb/sv/lbaf_rule_checker.sv -----
`timescale 1ns / 1ps
// Rule checker for the LBA interval rule flattener testbench.
// Watches the input, output and register ports, predicts the rule stream and
// compares it field by field. Depends on lbaf_pkg.
module lbaf_rule_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        cmd,
    input  logic [47:0] hint_first_lba,
    input  logic [47:0] hint_blocks,
    input  logic [7:0]  hint_dest,
    input  logic [47:0] hint_dest_lba,
    input  logic        target_usable,
    input  logic        target_available,
    input  logic        authoritative,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [47:0] rule_first_lba,
    input  logic [7:0]  rule_target,
    input  logic [47:0] rule_target_lba,
    input  logic        is_default,
    input  logic        overflowed,
    input  logic        last_of_run,
    input  logic        table_done,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [47:0] cfg_data,
    output int          fails,
    output int          pending,
    output int          rules_seen,
    output int          tables_seen
);

    localparam int SLOTS = lbaf_pkg::STACK_DEPTH_DEF + 1;
    localparam logic [47:0] LBA_MAX = '1;

    typedef struct packed {
        logic [47:0] first_lba;
        logic [7:0]  target;
        logic [47:0] target_lba;
        logic        dflt;
        logic        ovf;
        logic        last;
        logic        done;
    } rule_t;

    rule_t expected_rules[$];

    logic [47:0] dev_blocks;
    logic [7:0]  dflt_target;
    logic [47:0] ext_first[SLOTS];
    logic [47:0] ext_last[SLOTS];
    logic [7:0]  ext_target[SLOTS];
    logic [47:0] ext_tlba[SLOTS];
    int          depth;
    logic [47:0] cursor;
    logic        at_end;
    logic        ovf_sticky;

    assign pending = expected_rules.size();

    function automatic logic [47:0] dev_end();
        return (dev_blocks == 0) ? 48'd1 : dev_blocks;
    endfunction

    task automatic load_bottom();
        ext_first[0]  = '0;
        ext_last[0]   = dev_end() - 48'd1;
        ext_target[0] = dflt_target;
        ext_tlba[0]   = '0;
    endtask

    task automatic new_table();
        load_bottom();
        depth  = 1;
        cursor = '0;
        at_end = 1'b0;
    endtask

    task automatic add_rule();
        rule_t r;
        int t;
        t = depth - 1;
        r.first_lba  = cursor;
        r.target     = ext_target[t];
        r.target_lba = cursor - ext_first[t] + ext_tlba[t];
        r.dflt       = (t == 0);
        r.ovf        = ovf_sticky;
        r.last       = 1'b0;
        r.done       = 1'b0;
        expected_rules.push_back(r);
    endtask

    // Step past the top extent, then drop every extent already covered.
    task automatic pass_top();
        if (!at_end && depth > 0)
        begin
            if (cursor < ext_last[depth-1])
                cursor = ext_last[depth-1];
            if (cursor >= dev_end())
                at_end = 1'b1;
            else
            begin
                cursor = cursor + 48'd1;
                if (cursor >= dev_end())
                    at_end = 1'b1;
            end
        end
        while (depth > 0 && (at_end || cursor > ext_last[depth-1]))
            depth--;
    endtask

    task automatic predict_rules();
        int          n0;
        logic [47:0] blk;
        logic [47:0] lst;
        n0 = expected_rules.size();
        if (cmd == lbaf_pkg::CMD_END)
        begin
            while (depth > 0)
            begin
                if (!at_end)
                    add_rule();
                pass_top();
            end
            if (expected_rules.size() > n0)
            begin
                expected_rules[$].last = 1'b1;
                expected_rules[$].done = 1'b1;
            end
            new_table();
            return;
        end
        blk = (hint_blocks == 0) ? 48'd1 : hint_blocks;
        lst = (blk - 48'd1 > LBA_MAX - hint_first_lba) ? LBA_MAX
                                                       : hint_first_lba + blk - 48'd1;
        if (!target_usable || (!authoritative && !target_available))
            return;
        if (at_end || depth == 0 || hint_first_lba >= dev_end())
            return;
        while (hint_first_lba > cursor && depth > 0 && !at_end)
        begin
            add_rule();
            if (ext_last[depth-1] >= hint_first_lba)
            begin
                cursor = hint_first_lba;
                break;
            end
            pass_top();
        end
        if (depth > 0 && !at_end)
        begin
            if (depth >= SLOTS)
                ovf_sticky = 1'b1;
            else
            begin
                ext_first[depth]  = hint_first_lba;
                ext_last[depth]   = lst;
                ext_target[depth] = hint_dest;
                ext_tlba[depth]   = hint_dest_lba;
                depth++;
            end
        end
        if (expected_rules.size() > n0)
            expected_rules[$].last = 1'b1;
    endtask

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("%0t: rule mismatch on %s: got %h, expected %h", $time, what, got, want);
        fails++;
    endtask

    task automatic check_rule();
        rule_t w;
        if (expected_rules.size() == 0)
        begin
            report_mismatch("unexpected rule_first_lba", rule_first_lba, '0);
            return;
        end
        w = expected_rules.pop_front();
        rules_seen++;
        if (table_done)
            tables_seen++;
        if (rule_first_lba !== w.first_lba)
            report_mismatch("rule_first_lba", rule_first_lba, w.first_lba);
        if (rule_target !== w.target)
            report_mismatch("rule_target", rule_target, w.target);
        if (rule_target_lba !== w.target_lba)
            report_mismatch("rule_target_lba", rule_target_lba, w.target_lba);
        if (is_default !== w.dflt)
            report_mismatch("is_default", is_default, w.dflt);
        if (overflowed !== w.ovf)
            report_mismatch("overflowed", overflowed, w.ovf);
        if (last_of_run !== w.last)
            report_mismatch("last_of_run", last_of_run, w.last);
        if (table_done !== w.done)
            report_mismatch("table_done", table_done, w.done);
    endtask

    initial
    begin
        fails = 0;
        rules_seen = 0;
        tables_seen = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            ext_first[i]  = '0;
            ext_last[i]   = '0;
            ext_target[i] = '0;
            ext_tlba[i]   = '0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_blocks  = lbaf_pkg::DEVICE_BLOCKS_RST[47:0];
            dflt_target = lbaf_pkg::DFLT_DEST_RST;
            ovf_sticky  = 1'b0;
            expected_rules.delete();
            new_table();
        end
        else
        begin
            if (out_valid && !out_stall)
                check_rule();
            if (cfg_we)
            begin
                if (cfg_index == lbaf_pkg::CFG_DEVICE_BLOCKS)
                    dev_blocks = cfg_data;
                else
                    dflt_target = cfg_data[7:0];
                load_bottom();
            end
            if (in_valid && !in_stall)
                predict_rules();
        end
    end
endmodule

// ----- tb/sv/tb_lba_interval_rule_flattener.sv -----
`timescale 1ns / 1ps
// Testbench top for the LBA interval rule flattener: clock, reset, hint stimulus, register
// phases and verdict. Depends on lbaf_pkg, lbaf_rule_checker and lba_interval_rule_flattener.
module tb_lba_interval_rule_flattener;

    localparam int IDLE_LIMIT  = 3000;
    localparam int ITEM_TARGET = 270;
    localparam logic [47:0] LBA_MAX = '1;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [47:0] hint_first_lba;
    logic [47:0] hint_blocks;
    logic [7:0]  hint_dest;
    logic [47:0] hint_dest_lba;
    logic        target_usable;
    logic        target_available;
    logic        authoritative;
    logic        out_valid;
    logic        out_stall;
    logic [47:0] rule_first_lba;
    logic [7:0]  rule_target;
    logic [47:0] rule_target_lba;
    logic        is_default;
    logic        overflowed;
    logic        last_of_run;
    logic        table_done;
    logic        cfg_we;
    logic        cfg_index;
    logic [47:0] cfg_data;

    int fails;
    int pending;
    int rules_seen;
    int tables_seen;
    int items_sent;
    int burst_left;
    int idle_cycles;
    int stall_mode;

    lba_interval_rule_flattener u_top (.*);

    lbaf_rule_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: switch stall pattern at random times (none, light, heavy).
    always @(posedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 30);
            default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [7:0] rand8();
        return 8'($urandom);
    endfunction

    function automatic logic rand1();
        return 1'($urandom);
    endfunction

    task automatic send_item(logic c, logic [47:0] s, logic [47:0] b, logic [7:0] t,
                             logic [47:0] tl, logic u, logic a, logic au);
        cmd              <= c;
        hint_first_lba   <= s;
        hint_blocks      <= b;
        hint_dest        <= t;
        hint_dest_lba    <= tl;
        target_usable    <= u;
        target_available <= a;
        authoritative    <= au;
        in_valid         <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic send_hint(logic [47:0] s, logic [47:0] b, logic [7:0] t, logic [47:0] tl);
        send_item(lbaf_pkg::CMD_HINT, s, b, t, tl, 1'b1, 1'b1, rand1());
    endtask

    task automatic end_table();
        send_item(lbaf_pkg::CMD_END, rand48(), rand48(), rand8(),
                  rand48(), rand1(), rand1(), rand1());
    endtask

    // Hold until every expected rule is out, then let the block settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [47:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic setup_table(logic [47:0] dev, logic [7:0] tgt);
        wait_drained();
        write_reg(lbaf_pkg::CFG_DEVICE_BLOCKS, dev);
        write_reg(lbaf_pkg::CFG_DFLT_DEST, {40'd0, tgt});
    endtask

    task automatic random_table(int tno);
        logic [47:0] dev;
        logic [47:0] pos;
        logic [47:0] prev_len;
        logic [47:0] len;
        logic [47:0] step;
        int          n;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            dev = 48'($urandom_range(8, 4000));
        else if (pick < 85)
            dev = rand48();
        else
            dev = LBA_MAX;
        setup_table(dev, rand8());
        n = $urandom_range(3, 20);
        pos = '0;
        prev_len = dev;
        for (int i = 0; i < n; i++)
        begin
            if (tno % 5 == 3 && i == n / 2)
                wait_drained();
            if ($urandom_range(0, 99) < 12)
            begin
                // noise: unsorted start and random flags
                send_item(lbaf_pkg::CMD_HINT,
                          (dev < 5000) ? 48'($urandom_range(0, 5000)) : rand48(),
                          rand48() >> $urandom_range(0, 47), rand8(),
                          rand48(), rand1(), rand1(), rand1());
                continue;
            end
            if (i > 0 && $urandom_range(0, 99) < 35)
                len = (prev_len > 48'd1) ? prev_len - 48'd1 - (prev_len >> $urandom_range(1, 8))
                                         : 48'd1;
            else
            begin
                step = (dev <= 4000) ? 48'($urandom_range(0, 32'(dev / 48'd6) + 1))
                                     : rand48() >> $urandom_range(8, 44);
                pos = (LBA_MAX - pos < step) ? LBA_MAX : pos + step;
                len = (dev <= 4000) ? 48'($urandom_range(1, 32'(dev / 48'd3) + 1))
                                    : rand48() >> $urandom_range(0, 44);
                if ($urandom_range(0, 19) == 0)
                    len = ($urandom_range(0, 1)) ? 48'd0 : LBA_MAX;
            end
            prev_len = len;
            send_item(lbaf_pkg::CMD_HINT, pos, len, rand8(), rand48(),
                      ($urandom_range(0, 99) < 92), ($urandom_range(0, 99) < 80),
                      rand1());
        end
        end_table();
        if ($urandom_range(0, 9) == 0)
            end_table();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = lbaf_pkg::CMD_HINT;
        hint_first_lba = '0;
        hint_blocks = '0;
        hint_dest = '0;
        hint_dest_lba = '0;
        target_usable = 1'b0;
        target_available = 1'b0;
        authoritative = 1'b0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = lbaf_pkg::CFG_DEVICE_BLOCKS;
        cfg_data = '0;
        stall_mode = 0;
        items_sent = 0;
        burst_left = 0;
        idle_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: zero-length hint, skipped hints, unavailable but authoritative.
        send_hint(48'd0, 48'd0, 8'h11, 48'h123);
        send_item(lbaf_pkg::CMD_HINT, 48'd4, 48'd8, 8'h22, 48'h0, 1'b0, 1'b1, 1'b1);
        send_item(lbaf_pkg::CMD_HINT, 48'd4, 48'd8, 8'h22, 48'h0, 1'b1, 1'b0, 1'b0);
        send_item(lbaf_pkg::CMD_HINT, 48'd4, 48'd8, 8'h33, LBA_MAX, 1'b1, 1'b0, 1'b1);
        end_table();

        // Small device: nested hints until the stack overflows, out of order, past end.
        setup_table(48'd64, 8'hFF);
        for (int i = 0; i < 18; i++)
            send_hint(48'd5, 48'(40 - i), 8'(i), 48'(i * 1000));
        send_hint(48'd1, 48'd2, 8'h44, 48'h5);
        send_hint(48'd64, 48'd2, 8'h55, 48'h5);
        end_table();

        // Zero-size device, then the largest device with a saturating extent, then a one-block device.
        setup_table(48'd0, 8'h00);
        send_hint(48'd0, 48'd1, 8'h66, 48'h0);
        end_table();
        setup_table(LBA_MAX, 8'hA5);
        send_hint(LBA_MAX - 48'd1, LBA_MAX, 8'h77, LBA_MAX);
        end_table();
        setup_table(48'd1, 8'h5A);
        end_table();

        for (int tno = 0; items_sent < ITEM_TARGET; tno++)
            random_table(tno);

        wait_drained();
        $display("%0d items sent, %0d rules checked over %0d completed tables",
                 items_sent, rules_seen, tables_seen);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ----- files.f -----
design/lbaf_pkg.sv
design/lba_interval_rule_flattener.sv
tb/sv/lbaf_rule_checker.sv
tb/sv/tb_lba_interval_rule_flattener.sv
